[rtl/stt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants of the software timer table
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_SET   = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_REARM = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [1:0] KIND_EXPIRY  = 2'd0;
  localparam logic [1:0] KIND_STORED  = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;
  localparam logic [1:0] KIND_FULL    = 2'd3;

  localparam logic [0:0] REG_TICK_SECONDS = 1'd0;
  localparam logic [0:0] REG_SET_ENABLED  = 1'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] duration;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic        once_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] period;
    logic [31:0] out_key_a;
    logic [31:0] out_key_b;
    logic        last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]  func;
    logic        refused;
    logic [31:0] period;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic        once_mode;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/stt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_front
// accepts commands, divides set durations bit-serially, emits classified cmds
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic [15:0] tick_seconds,
  input  wire logic     set_enabled,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  cmd_t        cmd_r;
  logic [31:0] quo_r;
  logic [15:0] rem_r, div_r;
  logic [4:0]  cnt_r;
  logic [16:0] trial;

  assign in_ready  = (state_r == S_IDLE);
  assign cmd_valid = (state_r == S_OUT);
  assign cmd_data  = cmd_r;
  assign trial     = {rem_r, quo_r[31]} - {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        if (in_data.func == FUNC_SET && set_enabled && in_data.duration != '0) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: if (cnt_r == 5'd31) state_nxt = S_OUT;
      S_OUT: if (cmd_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      S_IDLE: begin
        cmd_r.func      <= in_data.func;
        cmd_r.refused   <= !set_enabled || in_data.duration == '0;
        cmd_r.period    <= '0;
        cmd_r.key_a     <= in_data.key_a;
        cmd_r.key_b     <= in_data.key_b;
        cmd_r.once_mode <= in_data.once_mode;
        quo_r <= in_data.duration;
        rem_r <= '0;
        cnt_r <= '0;
        div_r <= (tick_seconds == '0) ? 16'd1 : tick_seconds;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!trial[16]) begin
          rem_r <= trial[15:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[14:0], quo_r[31]};
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          cmd_r.period <= (quo_r[30:0] == '0 && trial[16]) ? 32'd1 :
                          {quo_r[30:0], !trial[16]};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/stt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_queue
// short fifo between the front and back parts
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire cmd_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_data
);

  cmd_t       mem_r [QUEUE_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= !wp_r;
      if (rd_valid && rd_ready) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

[rtl/stt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_back
// timer slot table: walks slots for tick, stop, rearm and set
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state_r;
  cmd_t   cmd_r;
  logic [IW-1:0] idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r, oneshot_r, wait_r;
  logic [31:0] ka_r [TABLE_ENTRIES];
  logic [31:0] kb_r [TABLE_ENTRIES];
  logic [31:0] per_r [TABLE_ENTRIES];
  logic [31:0] rem_r [TABLE_ENTRIES];

  // one held expiry so last can be marked once the walk ends
  logic      pend_r;
  out_item_t pend_data_r;
  logic      ovalid_r;
  out_item_t odata_r;

  logic [31:0] dec;
  logic        hit, expire, match, at_end, out_free, load_out;

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign out_free  = !ovalid_r || out_ready;
  assign dec       = rem_r[idx_r] - 32'd1;
  assign hit       = valid_r[idx_r] && !wait_r[idx_r];
  assign expire    = hit && dec == '0;
  assign match     = valid_r[idx_r] && ka_r[idx_r] == cmd_r.key_a &&
                     kb_r[idx_r] == cmd_r.key_b;
  assign at_end    = (idx_r == LAST_IDX);
  assign load_out  = (state_r == S_WALK && cmd_r.func == FUNC_TICK && expire && pend_r &&
                      out_free) ||
                     (state_r == S_WALK && cmd_r.func == FUNC_SET && out_free &&
                      (cmd_r.refused || !valid_r[idx_r] || at_end)) ||
                     (state_r == S_FLUSH && pend_r && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (load_out) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (cmd_valid) begin
          cmd_r <= cmd_data;
          idx_r <= '0;
          if (cmd_data.func == FUNC_CLEAR) begin
            valid_r <= '0;
          end else if (cmd_data.func <= FUNC_REARM) begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          case (cmd_r.func)
            FUNC_TICK: if (!(expire && pend_r && !out_free)) begin
              if (hit) begin
                rem_r[idx_r] <= expire ? per_r[idx_r] : dec;
                if (expire) begin
                  if (oneshot_r[idx_r]) valid_r[idx_r] <= 1'b0;
                  else wait_r[idx_r] <= 1'b1;
                  if (pend_r) begin
                    odata_r <= '{kind: pend_data_r.kind, period: pend_data_r.period,
                                 out_key_a: pend_data_r.out_key_a,
                                 out_key_b: pend_data_r.out_key_b, last: 1'b0};
                  end
                  pend_r <= 1'b1;
                  pend_data_r <= '{kind: KIND_EXPIRY, period: per_r[idx_r],
                                   out_key_a: ka_r[idx_r], out_key_b: kb_r[idx_r],
                                   last: 1'b1};
                end
              end
              idx_r <= idx_r + IW'(1);
              if (at_end) state_r <= S_FLUSH;
            end
            FUNC_SET: begin
              if (cmd_r.refused) begin
                if (out_free) begin
                  odata_r  <= '{kind: KIND_REFUSED, period: '0, out_key_a: cmd_r.key_a,
                                out_key_b: cmd_r.key_b, last: 1'b1};
                  state_r  <= S_IDLE;
                end
              end else if (!valid_r[idx_r]) begin
                if (out_free) begin
                  valid_r[idx_r]   <= 1'b1;
                  ka_r[idx_r]      <= cmd_r.key_a;
                  kb_r[idx_r]      <= cmd_r.key_b;
                  per_r[idx_r]     <= cmd_r.period;
                  rem_r[idx_r]     <= cmd_r.period;
                  oneshot_r[idx_r] <= cmd_r.once_mode;
                  wait_r[idx_r]    <= 1'b0;
                  odata_r  <= '{kind: KIND_STORED, period: '0, out_key_a: cmd_r.key_a,
                                out_key_b: cmd_r.key_b, last: 1'b1};
                  state_r  <= S_IDLE;
                end
              end else if (at_end) begin
                if (out_free) begin
                  odata_r  <= '{kind: KIND_FULL, period: '0, out_key_a: cmd_r.key_a,
                                out_key_b: cmd_r.key_b, last: 1'b1};
                  state_r  <= S_IDLE;
                end
              end else begin
                idx_r <= idx_r + IW'(1);
              end
            end
            default: begin
              if (match) begin
                if (cmd_r.func == FUNC_STOP) valid_r[idx_r] <= 1'b0;
                else wait_r[idx_r] <= 1'b0;
                state_r <= S_IDLE;
              end else if (at_end) begin
                state_r <= S_IDLE;
              end
              idx_r <= idx_r + IW'(1);
            end
          endcase
        end
        S_FLUSH: begin
          if (!pend_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            odata_r  <= pend_data_r;
            pend_r   <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/software_timer_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_table
// table of one-shot and periodic timers keyed by two 32-bit keys
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_item_t
//   out_     out  out_valid/out_ready  out_item_t
//   cfg_     in   apb psel/penable     tick_seconds, set_enabled
//
// an enabled set with nonzero duration runs the front's 32-step divider
// tick, stop and rearm walk one slot per cycle; a stalled output holds tick
// clear and unused codes finish in the back's idle state, with no walk
// a 2-entry queue lets the front divide while the back walks the table
// synchronous active-low reset empties the table, no clearing pass
// ----------------------------------------------------------------------------
module software_timer_table import stt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:2]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [15:0] tick_seconds_r;
  logic        set_enabled_r;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t        fq_data, qb_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SET_ENABLED) ? {31'd0, set_enabled_r} :
                      {16'd0, tick_seconds_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_seconds_r <= 16'd1;
      set_enabled_r  <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_TICK_SECONDS) tick_seconds_r <= cfg_pwdata[15:0];
      else set_enabled_r <= cfg_pwdata[0];
    end
  end

  stt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .tick_seconds(tick_seconds_r), .set_enabled(set_enabled_r),
    .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd_data(fq_data)
  );

  stt_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  stt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst_n,
    .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd_data(qb_data),
    .out_valid, .out_ready, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");

  a_period_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_EXPIRY |-> out_data.period == '0 && out_data.last)
    else $error("set result malformed");

  a_expiry_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_EXPIRY |-> out_data.period != '0)
    else $error("zero period expiry");

endmodule
`default_nettype wire
